>>> src/olb_pkg.sv
// Shared types and constants for the ordered list buffer.
// Holds the request and result structs, operation and status codes, cell control.
// No dependencies.
`timescale 1ns / 1ps

package olb_pkg;

  localparam int DATA_W = 32;
  localparam int LEAF_W = DATA_W + 1;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_END   = 3'd1;
  localparam logic [2:0] OP_INS_POS   = 3'd2;
  localparam logic [2:0] OP_DELETE    = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;
  localparam logic [2:0] OP_SEARCH    = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] item_value;
    logic [6:0]               position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [6:0]               entry_count;
  } out_item_t;

  typedef struct packed {
    logic insert_en;
    logic delete_en;
    logic pick_en;
    logic match_en;
  } cell_ctl_t;

endpackage

>>> src/olb_cell.sv
// One list entry of the ordered list buffer: shifts with its neighbors and
// registers its share of a read or search result.
// Depends on olb_pkg.
`timescale 1ns / 1ps

module olb_cell import olb_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [IW-1:0]            at,
  input  logic [CW-1:0]            cnt,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value,
  output logic [LEAF_W-1:0]        leaf
);

  logic at_here;
  logic live;
  logic match;

  assign at_here = (IW'(IDX) == at);
  assign live    = (CW'(IDX) < cnt);
  assign match   = ctl.match_en && live && (value == key);

  always_ff @(posedge clk) begin
    if (ctl.insert_en) begin
      if (at_here) begin
        value <= key;
      end else if (IW'(IDX) > at) begin
        value <= left_value;
      end
    end else if (ctl.delete_en && (IW'(IDX) >= at)) begin
      value <= right_value;
    end
    leaf <= {match, (ctl.pick_en && at_here) ? value : {DATA_W{1'b0}}};
  end

endmodule

>>> src/olb_or_tree.sv
// Registered OR reduction tree that gathers the cell results into one word.
// Depends on nothing.
`timescale 1ns / 1ps

module olb_or_tree #(
  parameter int LEAVES = 64,
  parameter int WIDTH  = 33
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] leaf [LEAVES],
  output logic [WIDTH-1:0] root
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int P      = 1 << LEVELS;

  logic [WIDTH-1:0] leaf_pad [P];
  logic [WIDTH-1:0] node [1:P-1];

  for (genvar j = 0; j < P; j++) begin : g_pad
    if (j < LEAVES) begin : g_used
      assign leaf_pad[j] = leaf[j];
    end else begin : g_zero
      assign leaf_pad[j] = '0;
    end
  end

  for (genvar k = 1; k < P; k++) begin : g_node
    if (2 * k >= P) begin : g_bottom
      always_ff @(posedge clk) begin
        node[k] <= leaf_pad[2*k-P] | leaf_pad[2*k+1-P];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[k] <= node[2*k] | node[2*k+1];
      end
    end
  end

  assign root = node[1];

endmodule

>>> src/ordered_list_buffer_unit.sv
// Ordered list buffer: a row of DEPTH cells holding signed 32-bit entries.
// The result strobe follows the execute state and the registered OR tree that gathers
// read and search data; a new transaction is taken only once the unit is idle again.
// Reset clears the entry count and control; entries are not cleared and need no pass.
`timescale 1ns / 1ps

module ordered_list_buffer_unit import olb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  request,
  output logic      busy,
  output logic      done,
  output out_item_t result
);

  localparam int IW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int LEVELS = $clog2(DEPTH);
  localparam int KW     = $clog2(LEVELS + 1);
  localparam int CMPW   = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                   state;
  in_item_t                 cmd;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [1:0]               status;
  logic [1:0]               status_next;
  logic [KW-1:0]            drain_cnt;

  cell_ctl_t                ctl;
  logic [IW-1:0]            at;
  logic                     full;
  logic                     in_range;
  logic                     is_insert;

  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic [LEAF_W-1:0]        cell_leaf [DEPTH];
  logic [LEAF_W-1:0]        root;

  assign full      = (count >= CW'(DEPTH));
  assign in_range  = (CMPW'(cmd.position) < CMPW'(count));
  assign is_insert = cmd.operation inside {OP_INS_FRONT, OP_INS_END, OP_INS_POS};

  always_comb begin
    ctl         = '0;
    at          = '0;
    status_next = ST_DONE;
    count_next  = count;
    if (state == S_EXEC) begin
      if (is_insert) begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.insert_en = 1'b1;
          count_next    = count + CW'(1);
          case (cmd.operation)
            OP_INS_FRONT: at = '0;
            OP_INS_POS:   at = in_range ? IW'(cmd.position) : IW'(count);
            default:      at = IW'(count);
          endcase
        end
      end else begin
        case (cmd.operation)
          OP_DELETE: begin
            if (!in_range) begin
              status_next = ST_RANGE;
            end else begin
              ctl.delete_en = 1'b1;
              ctl.pick_en   = 1'b1;
              at            = IW'(cmd.position);
              count_next    = count - CW'(1);
            end
          end
          OP_READ: begin
            if (!in_range) begin
              status_next = ST_RANGE;
            end else begin
              ctl.pick_en = 1'b1;
              at          = IW'(cmd.position);
            end
          end
          OP_SEARCH: begin
            ctl.match_en = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      status    <= ST_DONE;
      drain_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count     <= count_next;
          status    <= status_next;
          drain_cnt <= KW'(LEVELS);
          state     <= S_DRAIN;
        end
        S_DRAIN: begin
          if (drain_cnt == '0) begin
            state <= S_IDLE;
          end else begin
            drain_cnt <= drain_cnt - KW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd <= request;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_left
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_right
      assign right_value = cell_value[i+1];
    end

    olb_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .at          (at),
      .cnt         (count),
      .key         (cmd.item_value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .leaf        (cell_leaf[i])
    );
  end

  olb_or_tree #(
    .LEAVES (DEPTH),
    .WIDTH  (LEAF_W)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_leaf),
    .root (root)
  );

  assign busy = (state != S_IDLE);
  assign done = (state == S_DRAIN) && (drain_cnt == '0);

  assign result.status      = status;
  assign result.read_value  = root[DATA_W-1:0];
  assign result.found       = root[DATA_W];
  assign result.entry_count = 7'(count);

endmodule

>>> src/olb_checker.sv
// Port-level checks for ordered_list_buffer_unit, attached by bind.
// Depends on olb_pkg and the top level's port names.
`timescale 1ns / 1ps

module olb_checker import olb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input out_item_t result
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a transaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not start");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("unit stayed busy after its result");

  a_fail_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_DONE)) |-> ((result.read_value == '0) && !result.found))
    else $error("refused transaction returned data");

endmodule

bind ordered_list_buffer_unit olb_checker u_olb_checker (.*);
